[rtl/gtpu_pkg.sv]
// Package for the GTP-U header parser: phase codes, register indexes and widths.
// Used by the parse datapath, the result stage and the top level.
package gtpu_pkg;

    localparam int CountWidthDefault = 48;
    localparam int MaxExtDefault     = 4;
    localparam int AddrWidth         = 3;

    localparam logic [15:0] TunnelPortReset    = 16'd2152;
    localparam logic [15:0] TunnelPortAltReset = 16'd2153;
    localparam logic [7:0]  ContainerType      = 8'h85;

    localparam logic [AddrWidth-1:0] RegTunnelPort    = 3'd0;
    localparam logic [AddrWidth-1:0] RegTunnelPortAlt = 3'd4;

    typedef enum logic [3:0] {
        PH_ETH      = 4'd0,
        PH_IP       = 4'd1,
        PH_UDP      = 4'd2,
        PH_GTP      = 4'd3,
        PH_OPT      = 4'd4,
        PH_EXT_LEN  = 4'd5,
        PH_EXT_BODY = 4'd6,
        PH_INNER    = 4'd7,
        PH_DROP     = 4'd8,
        PH_PLAIN    = 4'd9,
        PH_DONE0    = 4'd10,
        PH_DONE2    = 4'd11,
        PH_DONE3    = 4'd12,
        PH_DONE4    = 4'd13
    } t_phase;

    localparam logic [1:0] ClassNone   = 2'd0;
    localparam logic [1:0] ClassUdp    = 2'd1;
    localparam logic [1:0] ClassTunnel = 2'd2;

    localparam logic [2:0] StatusOk        = 3'd0;
    localparam logic [2:0] StatusTrunc     = 3'd1;
    localparam logic [2:0] StatusBadExtLen = 3'd2;
    localparam logic [2:0] StatusLongChain = 3'd3;
    localparam logic [2:0] StatusInnerBad  = 3'd4;

    // Per-frame verdict handed from the parser to the result stage.
    typedef struct packed {
        logic [1:0]  packet_class;
        logic [2:0]  parse_status;
        logic [63:0] outer_addresses;
        logic [31:0] outer_ports;
        logic [31:0] tunnel_id;
        logic [23:0] tunnel_header_info;
        logic [25:0] sequence_and_npdu;
        logic [34:0] extension_chain;
        logic [10:0] session_info;
        logic [63:0] inner_addresses;
        logic [8:0]  inner_info;
    } t_verdict;

endpackage

[rtl/gtpu_if.sv]
// Channel interfaces for the GTP-U header parser: byte stream in, frame result out.
// Standalone; the result field widths match t_verdict in gtpu_pkg.
interface gtpu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;
    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface gtpu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  packet_class;
    logic [63:0] outer_addresses;
    logic [31:0] outer_ports;
    logic [31:0] tunnel_id;
    logic [23:0] tunnel_header_info;
    logic [25:0] sequence_and_npdu;
    logic [34:0] extension_chain;
    logic [10:0] session_info;
    logic [63:0] inner_addresses;
    logic [8:0]  inner_info;
    logic [2:0]  parse_status;
    logic [47:0] class_count;
    modport source (output valid, output packet_class, output outer_addresses,
        output outer_ports, output tunnel_id, output tunnel_header_info,
        output sequence_and_npdu, output extension_chain, output session_info,
        output inner_addresses, output inner_info, output parse_status,
        output class_count, input ready);
    modport sink (input valid, input packet_class, input outer_addresses,
        input outer_ports, input tunnel_id, input tunnel_header_info,
        input sequence_and_npdu, input extension_chain, input session_info,
        input inner_addresses, input inner_info, input parse_status,
        input class_count, output ready);
endinterface

[rtl/gtpu_parse.sv]
// Byte-at-a-time parse state for Ethernet, IPv4, UDP, GTP-U and the inner IPv4 header.
// Depends on gtpu_pkg. Emits one verdict on the last byte of each frame.
module gtpu_parse
    import gtpu_pkg::*;
#(
    parameter int MAX_EXTENSIONS = MaxExtDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_port0,
    input  logic [15:0] i_port1,
    output t_verdict    o_verdict
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_off, n_off;
    logic [7:0]  r_hlen, n_hlen;
    logic [8:0]  r_left, n_left;
    logic [7:0]  r_next, n_next;
    logic [63:0] r_oaddr, n_oaddr;
    logic [31:0] r_ports, n_ports;
    logic [31:0] r_teid, n_teid;
    logic [23:0] r_hdr, n_hdr;
    logic [25:0] r_seq, n_seq;
    logic [34:0] r_chain, n_chain;
    logic [10:0] r_sess, n_sess;
    logic [63:0] r_iaddr, n_iaddr;
    logic [8:0]  r_iinfo, n_iinfo;
    logic [31:0] r_tmp, n_tmp;

    logic        advance;
    logic [7:0]  fl_now;
    logic [7:0]  walked;
    logic [7:0]  walked_now;
    logic [2:0]  cnt;
    logic [16:0] off_p1;
    logic        port_hit;
    t_phase      chain_phase;
    logic        chain_to_inner;

    assign off_p1 = {1'b0, r_off} + 17'd1;
    assign fl_now = r_hdr[23:16];
    assign walked = r_tmp[7:0];
    // The optional bytes come before any extension, so no extension is walked yet.
    assign walked_now = (r_phase == PH_OPT) ? 8'd0 : walked;
    assign cnt    = r_chain[34:32];
    assign port_hit = (r_ports[31:16] == i_port0) || (r_ports[15:0] == i_port0) ||
                      (r_ports[31:16] == i_port1) || (r_ports[15:0] == i_port1);

    // Verdict after optional bytes or one extension, given the next type in n_next.
    always_comb begin
        chain_to_inner = 1'b0;
        chain_phase    = PH_INNER;
        if (fl_now[2] && (n_next != 8'd0)) begin
            if (walked_now < 8'(MAX_EXTENSIONS)) chain_phase = PH_EXT_LEN;
            else chain_phase = PH_DONE3;
        end else begin
            chain_to_inner = 1'b1;
        end
    end

    always_comb begin
        n_phase = r_phase; n_off = r_off; n_hlen = r_hlen; n_left = r_left;
        n_next = r_next; n_oaddr = r_oaddr; n_ports = r_ports; n_teid = r_teid;
        n_hdr = r_hdr; n_seq = r_seq; n_chain = r_chain; n_sess = r_sess;
        n_iaddr = r_iaddr; n_iinfo = r_iinfo; n_tmp = r_tmp;
        advance = 1'b1;
        case (r_phase)
            PH_ETH: begin
                if (r_off >= 16'd12) n_tmp = {16'd0, r_tmp[7:0], i_byte};
                if (r_off == 16'd13) begin
                    n_phase = ({r_tmp[7:0], i_byte} == 16'h0800) ? PH_IP : PH_DROP;
                    n_off = '0; n_tmp = '0; advance = 1'b0;
                end
            end
            PH_IP: begin
                if (r_off == 16'd0) n_hlen = {2'b00, i_byte[3:0], 2'b00};
                if (r_off == 16'd9) n_tmp = {24'd0, i_byte};
                if (r_off >= 16'd12 && r_off <= 16'd19) n_oaddr = {r_oaddr[55:0], i_byte};
                if (r_off == 16'd19 && (r_tmp != 32'd17 || r_hlen < 8'd20)) begin
                    n_phase = PH_DROP; n_off = '0; advance = 1'b0;
                end else if (r_off >= 16'd19 && off_p1 >= {9'd0, r_hlen}) begin
                    n_phase = PH_UDP; n_off = '0; advance = 1'b0;
                end
            end
            PH_UDP: begin
                if (r_off < 16'd4) n_ports = {r_ports[23:0], i_byte};
                if (r_off == 16'd7) begin
                    n_tmp = '0; n_off = '0; advance = 1'b0;
                    n_phase = port_hit ? PH_GTP : PH_PLAIN;
                end
            end
            PH_GTP: begin
                if (r_off == 16'd0) n_hdr = {i_byte, 16'd0};
                else if (r_off == 16'd1) n_tmp = {24'd0, i_byte};
                else if (r_off == 16'd2) n_hdr = {r_hdr[23:16], i_byte, r_hdr[7:0]};
                else if (r_off == 16'd3) n_hdr = {r_hdr[23:8], i_byte};
                else n_teid = {r_teid[23:0], i_byte};
                if (r_off == 16'd7) begin
                    advance = 1'b0; n_off = '0;
                    if (fl_now[7:5] != 3'd1 || !fl_now[4] || r_tmp != 32'd255) begin
                        n_phase = PH_PLAIN;
                    end else if (fl_now[2:0] != 3'd0) begin
                        n_tmp = '0; n_phase = PH_OPT;
                    end else begin
                        // No optional bytes: no extension follows.
                        n_tmp = '0; n_next = '0; n_hlen = '0; n_phase = PH_INNER;
                    end
                end
            end
            PH_OPT: begin
                n_tmp = {r_tmp[23:0], i_byte};
                if (r_off == 16'd3) begin
                    n_seq = '0;
                    if (fl_now[1]) n_seq[25:8] = {2'b10, r_tmp[23:8]};
                    if (fl_now[0]) begin
                        n_seq[24] = 1'b1; n_seq[7:0] = r_tmp[7:0];
                    end
                    n_next = i_byte;
                    n_tmp = '0;
                    n_off = '0; advance = 1'b0;
                    n_phase = chain_phase;
                    if (chain_to_inner) n_hlen = '0;
                end
            end
            PH_EXT_LEN: begin
                advance = 1'b0;
                if (i_byte == 8'd0 || i_byte > 8'd64) begin
                    n_phase = PH_DONE2; n_off = '0;
                end else begin
                    if (walked < 8'd4) n_chain[31:0] = r_chain[31:0] |
                        ({24'd0, r_next} << {walked[1:0], 3'b000});
                    n_chain[34:32] = (cnt < 3'd7) ? cnt + 3'd1 : cnt;
                    n_tmp = {r_tmp[31:8], walked + 8'd1};
                    n_left = {i_byte[6:0], 2'b00} - 9'd1;
                    n_phase = PH_EXT_BODY; n_off = 16'd1;
                end
            end
            PH_EXT_BODY: begin
                if (r_next == ContainerType) begin
                    if (r_off == 16'd1) n_tmp = {16'd0, i_byte, r_tmp[7:0]};
                    else if (r_off == 16'd2)
                        n_sess = {1'b1, r_tmp[15:12], i_byte[5:0]};
                end
                n_left = r_left - 9'd1;
                if (n_left == 9'd0) begin
                    n_next = i_byte; advance = 1'b0; n_off = '0;
                    n_phase = chain_phase;
                    if (chain_to_inner) begin
                        n_tmp = '0; n_hlen = '0;
                    end
                end
            end
            PH_INNER: begin
                if (r_off == 16'd0) begin
                    n_hlen = {2'b00, i_byte[3:0], 2'b00}; n_tmp = {24'd0, i_byte};
                end
                if (r_off == 16'd9) n_tmp = {r_tmp[31:16], i_byte, r_tmp[7:0]};
                if (r_off >= 16'd12 && r_off <= 16'd19) n_iaddr = {r_iaddr[55:0], i_byte};
                if (r_off == 16'd19 && (r_tmp[7:4] != 4'd4 || r_hlen < 8'd20)) begin
                    n_phase = PH_DONE4; n_off = '0; advance = 1'b0;
                end else if (r_off >= 16'd19 && off_p1 >= {9'd0, r_hlen}) begin
                    n_iinfo = {1'b1, r_tmp[15:8]};
                    n_phase = PH_DONE0; n_off = '0; advance = 1'b0;
                end
            end
            default: advance = 1'b0;
        endcase
        if (advance && r_off != 16'hffff) n_off = off_p1[15:0];
    end

    // Verdict from the post-byte state.
    always_comb begin
        o_verdict = '0;
        case (n_phase)
            PH_GTP, PH_PLAIN: o_verdict.packet_class = ClassUdp;
            PH_OPT, PH_EXT_LEN, PH_EXT_BODY, PH_INNER: begin
                o_verdict.packet_class = ClassTunnel; o_verdict.parse_status = StatusTrunc;
            end
            PH_DONE0: o_verdict.packet_class = ClassTunnel;
            PH_DONE2: begin
                o_verdict.packet_class = ClassTunnel; o_verdict.parse_status = StatusBadExtLen;
            end
            PH_DONE3: begin
                o_verdict.packet_class = ClassTunnel; o_verdict.parse_status = StatusLongChain;
            end
            PH_DONE4: begin
                o_verdict.packet_class = ClassTunnel; o_verdict.parse_status = StatusInnerBad;
            end
            default: o_verdict.packet_class = ClassNone;
        endcase
        if (o_verdict.packet_class != ClassNone) begin
            o_verdict.outer_addresses = n_oaddr;
            o_verdict.outer_ports     = n_ports;
        end
        if (o_verdict.packet_class == ClassTunnel) begin
            o_verdict.tunnel_id          = n_teid;
            o_verdict.tunnel_header_info = n_hdr;
            o_verdict.sequence_and_npdu  = n_seq;
            o_verdict.extension_chain    = n_chain;
            o_verdict.session_info       = n_sess;
            if (n_phase == PH_DONE0) begin
                o_verdict.inner_addresses = n_iaddr;
                o_verdict.inner_info      = n_iinfo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase <= PH_ETH; r_off <= '0; r_hlen <= '0; r_left <= '0; r_next <= '0;
            r_oaddr <= '0; r_ports <= '0; r_teid <= '0; r_hdr <= '0; r_seq <= '0;
            r_chain <= '0; r_sess <= '0; r_iaddr <= '0; r_iinfo <= '0; r_tmp <= '0;
        end else if (i_en) begin
            r_phase <= n_phase; r_off <= n_off; r_hlen <= n_hlen; r_left <= n_left;
            r_next <= n_next; r_oaddr <= n_oaddr; r_ports <= n_ports; r_teid <= n_teid;
            r_hdr <= n_hdr; r_seq <= n_seq; r_chain <= n_chain; r_sess <= n_sess;
            r_iaddr <= n_iaddr; r_iinfo <= n_iinfo; r_tmp <= n_tmp;
        end
    end

endmodule

[rtl/gtpu_result.sv]
// Result stage: class counters and the output register of the GTP-U parser.
// Depends on gtpu_pkg and gtpu_out_if.
module gtpu_result
    import gtpu_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_verdict i_verdict,
    output logic     o_free,
    gtpu_out_if.source out_if
);

    logic [COUNT_WIDTH-1:0] r_cnt_udp, r_cnt_tun, n_cnt_udp, n_cnt_tun;
    logic                   r_valid;
    t_verdict               r_res;
    logic [47:0]            r_count, n_count;
    logic [63:0]            cnt_ext;

    assign n_cnt_udp = r_cnt_udp + COUNT_WIDTH'(1);
    assign n_cnt_tun = r_cnt_tun + COUNT_WIDTH'(1);
    assign o_free = !r_valid || out_if.ready;

    always_comb begin
        cnt_ext = '0;
        if (i_verdict.packet_class == ClassUdp) cnt_ext = 64'(n_cnt_udp);
        else if (i_verdict.packet_class == ClassTunnel) cnt_ext = 64'(n_cnt_tun);
        n_count = cnt_ext[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_cnt_udp <= '0; r_cnt_tun <= '0;
        end else begin
            if (out_if.ready) r_valid <= 1'b0;
            if (i_load) begin
                r_valid <= 1'b1;
                if (i_verdict.packet_class == ClassUdp) r_cnt_udp <= n_cnt_udp;
                if (i_verdict.packet_class == ClassTunnel) r_cnt_tun <= n_cnt_tun;
            end
        end
        if (i_load) begin
            r_res <= i_verdict; r_count <= n_count;
        end
    end

    assign out_if.valid              = r_valid;
    assign out_if.packet_class       = r_res.packet_class;
    assign out_if.outer_addresses    = r_res.outer_addresses;
    assign out_if.outer_ports        = r_res.outer_ports;
    assign out_if.tunnel_id          = r_res.tunnel_id;
    assign out_if.tunnel_header_info = r_res.tunnel_header_info;
    assign out_if.sequence_and_npdu  = r_res.sequence_and_npdu;
    assign out_if.extension_chain    = r_res.extension_chain;
    assign out_if.session_info       = r_res.session_info;
    assign out_if.inner_addresses    = r_res.inner_addresses;
    assign out_if.inner_info         = r_res.inner_info;
    assign out_if.parse_status       = r_res.parse_status;
    assign out_if.class_count        = r_count;

endmodule

[rtl/gtpu_header_parser.sv]
// GTP-U header parser top level: configuration port, byte parser and result stage.
// Depends on gtpu_pkg, gtpu_if, gtpu_parse and gtpu_result.
//
// Frame bytes enter one per beat on in_if, first byte the destination MAC, with
// frame_last on the final byte. The parser updates its state on every accepted
// beat; on the last beat of a frame it registers one result, which shows on
// out_if in the next cycle. in_if.ready falls only while a result waits in the
// output register and the receiver holds out_if.ready low; a byte that is not
// last is taken even then, since it produces no result. Otherwise throughput is
// one byte per cycle, set by the single parse register stage. Write the tunnel
// ports (APB byte addresses 0 and 4) only while the block is idle; the block
// does not enforce it. Reset (i_rst_n low, synchronous) restores the ports to
// 2152 and 2153, clears both class counters and the parse state.
module gtpu_header_parser
    import gtpu_pkg::*;
#(
    parameter int MAX_EXTENSIONS = MaxExtDefault,
    parameter int COUNT_WIDTH    = CountWidthDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    gtpu_in_if.sink              in_if,
    gtpu_out_if.source           out_if
);

    logic [15:0] r_port0, r_port1;
    logic        free, take, wr;
    t_verdict    verdict;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port0 <= TunnelPortReset; r_port1 <= TunnelPortAltReset;
        end else if (wr) begin
            if (paddr == RegTunnelPort) r_port0 <= pwdata[15:0];
            if (paddr == RegTunnelPortAlt) r_port1 <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == RegTunnelPort) prdata = {16'd0, r_port0};
        else if (paddr == RegTunnelPortAlt) prdata = {16'd0, r_port1};
    end

    assign in_if.ready = free || !in_if.frame_last;
    assign take = in_if.valid && in_if.ready;

    gtpu_parse #(.MAX_EXTENSIONS(MAX_EXTENSIONS)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(take), .i_byte(in_if.frame_byte),
        .i_last(in_if.frame_last), .i_port0(r_port0), .i_port1(r_port1),
        .o_verdict(verdict)
    );

    gtpu_result #(.COUNT_WIDTH(COUNT_WIDTH)) u_result (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(take && in_if.frame_last),
        .i_verdict(verdict), .o_free(free), .out_if(out_if)
    );

`ifndef ASSERT_OFF
    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && in_if.frame_last |=> out_if.valid)
        else $error("last beat did not produce a result");
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(take && in_if.frame_last) && !$past(out_if.valid) |-> !out_if.valid)
        else $error("result appeared without a last beat");
    a_class0_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid && out_if.packet_class == ClassNone |->
        out_if.class_count == 48'd0 && out_if.parse_status == StatusOk)
        else $error("class zero result carries data");
`endif

endmodule

[verif/tb_top.sv]
// Testbench for the GTP-U header parser: random and hand-built frames, byte per beat.
// Depends on gtpu_pkg, the channel interfaces in gtpu_if and the gtpu_header_parser top level.
module tb_top;
    import gtpu_pkg::*;

    localparam int IdleLimit = 5000;

    // Capture slots of the per-frame field store.
    localparam int FcOuterAddr = 0;
    localparam int FcPorts     = 1;
    localparam int FcTeid      = 2;
    localparam int FcHdr       = 3;
    localparam int FcSeq       = 4;
    localparam int FcChain     = 5;
    localparam int FcSession   = 6;
    localparam int FcInnerAddr = 7;
    localparam int FcInnerInfo = 8;
    localparam int FcScratch   = 9;

    typedef struct {
        t_verdict    v;
        logic [47:0] count;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    gtpu_in_if  in_if ();
    gtpu_out_if out_if ();

    gtpu_header_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_if   (in_if),
        .out_if  (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Parser state mirror.
    logic [15:0]   port_main, port_alt;
    t_phase        ph;
    int            pos;
    logic [7:0]    hdr_len;
    logic [8:0]    ext_left;
    logic [7:0]    next_ext;
    logic [63:0]   fc [10];
    logic [47:0]   tunnel_cnt, udp_cnt;

    t_frame_result expected_results [$];
    logic [7:0]    frame_bytes [$];
    int            errors = 0;
    int            idle_cycles = 0;
    int            hold_off = 0;
    int            stall_left = 0;
    bit            calm = 0;

    initial begin
        in_if.valid = 1'b0;
        in_if.frame_byte = '0;
        in_if.frame_last = 1'b0;
        out_if.ready = 1'b1;
    end

    function automatic void clear_frame_state();
        pos = 0;
        ph = PH_ETH;
        hdr_len = '0;
        ext_left = '0;
        next_ext = '0;
        foreach (fc[k]) fc[k] = '0;
    endfunction

    function automatic void go_to(input t_phase p);
        ph = p;
        pos = 0;
    endfunction

    // Chooses between another extension, a too-long chain and the inner header.
    function automatic void chain_next();
        logic [7:0] fl;
        fl = fc[FcHdr][23:16];
        if (fl[2] && next_ext != 0) begin
            if (fc[FcScratch][7:0] < MaxExtDefault) go_to(PH_EXT_LEN);
            else go_to(PH_DONE3);
        end else begin
            fc[FcScratch] = '0;
            hdr_len = '0;
            go_to(PH_INNER);
        end
    endfunction

    function automatic void note_ext_kind();
        logic [7:0]  walked;
        logic [63:0] chain;
        logic [2:0]  n;
        walked = fc[FcScratch][7:0];
        chain = fc[FcChain];
        n = chain[34:32];
        if (walked < 4) chain[31:0] = chain[31:0] | (32'(next_ext) << (8 * walked));
        if (n < 7) n++;
        fc[FcChain] = {29'd0, n, chain[31:0]};
        fc[FcScratch][7:0] = walked + 8'd1;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        bit          adv;
        logic [7:0]  fl;
        logic [63:0] raw, sq;
        logic [15:0] s, d;
        adv = 1;
        case (ph)
            PH_ETH: begin
                if (pos >= 12) fc[FcScratch] = ((fc[FcScratch] << 8) | b) & 64'hffff;
                if (pos == 13) begin
                    go_to(fc[FcScratch] == 64'h0800 ? PH_IP : PH_DROP);
                    fc[FcScratch] = '0;
                    adv = 0;
                end
            end
            PH_IP: begin
                if (pos == 0) hdr_len = {2'b00, b[3:0], 2'b00};
                if (pos == 9) fc[FcScratch] = 64'(b);
                if (pos >= 12 && pos <= 19) fc[FcOuterAddr] = (fc[FcOuterAddr] << 8) | b;
                if (pos == 19 && (fc[FcScratch] != 17 || hdr_len < 20)) begin
                    go_to(PH_DROP);
                    adv = 0;
                end else if (pos >= 19 && pos + 1 >= hdr_len) begin
                    go_to(PH_UDP);
                    adv = 0;
                end
            end
            PH_UDP: begin
                if (pos < 4) fc[FcPorts] = ((fc[FcPorts] << 8) | b) & 64'hffffffff;
                if (pos == 7) begin
                    s = fc[FcPorts][31:16];
                    d = fc[FcPorts][15:0];
                    fc[FcScratch] = '0;
                    go_to((s == port_main || d == port_main || s == port_alt ||
                           d == port_alt) ? PH_GTP : PH_PLAIN);
                    adv = 0;
                end
            end
            PH_GTP: begin
                if (pos == 0) fc[FcHdr] = 64'(b) << 16;
                else if (pos == 1) fc[FcScratch] = 64'(b);
                else if (pos == 2) fc[FcHdr][15:8] = b;
                else if (pos == 3) fc[FcHdr][7:0] = b;
                else fc[FcTeid] = ((fc[FcTeid] << 8) | b) & 64'hffffffff;
                if (pos == 7) begin
                    fl = fc[FcHdr][23:16];
                    if (fl[7:5] != 3'd1 || !fl[4] || fc[FcScratch] != 255) begin
                        go_to(PH_PLAIN);
                    end else if (fl[2:0] != 0) begin
                        fc[FcScratch] = '0;
                        go_to(PH_OPT);
                    end else begin
                        fc[FcScratch] = '0;
                        next_ext = '0;
                        chain_next();
                    end
                    adv = 0;
                end
            end
            PH_OPT: begin
                fc[FcScratch] = ((fc[FcScratch] << 8) | b) & 64'hffffffff;
                if (pos == 3) begin
                    raw = fc[FcScratch];
                    fl = fc[FcHdr][23:16];
                    sq = '0;
                    if (fl[1]) sq = sq | (64'd1 << 25) | (64'(raw[31:16]) << 8);
                    if (fl[0]) sq = sq | (64'd1 << 24) | 64'(raw[15:8]);
                    fc[FcSeq] = sq;
                    next_ext = raw[7:0];
                    fc[FcScratch] = '0;
                    chain_next();
                    adv = 0;
                end
            end
            PH_EXT_LEN: begin
                if (b == 0 || b > 64) begin
                    go_to(PH_DONE2);
                end else begin
                    note_ext_kind();
                    ext_left = 9'(b) * 9'd4 - 9'd1;
                    ph = PH_EXT_BODY;
                    pos = 1;
                end
                adv = 0;
            end
            PH_EXT_BODY: begin
                if (next_ext == ContainerType) begin
                    if (pos == 1) begin
                        fc[FcScratch][63:8] = 56'(b);
                    end else if (pos == 2) begin
                        fc[FcSession] = (64'd1 << 10) | (64'(fc[FcScratch][15:12]) << 6) |
                                        64'(b[5:0]);
                    end
                end
                ext_left = ext_left - 9'd1;
                if (ext_left == 0) begin
                    next_ext = b;
                    chain_next();
                    adv = 0;
                end
            end
            PH_INNER: begin
                if (pos == 0) begin
                    hdr_len = {2'b00, b[3:0], 2'b00};
                    fc[FcScratch] = 64'(b);
                end
                if (pos == 9) fc[FcScratch][15:8] = b;
                if (pos >= 12 && pos <= 19) fc[FcInnerAddr] = (fc[FcInnerAddr] << 8) | b;
                if (pos == 19 && (fc[FcScratch][7:4] != 4 || hdr_len < 20)) begin
                    go_to(PH_DONE4);
                    adv = 0;
                end else if (pos >= 19 && pos + 1 >= hdr_len) begin
                    fc[FcInnerInfo] = 64'h100 | 64'(fc[FcScratch][15:8]);
                    go_to(PH_DONE0);
                    adv = 0;
                end
            end
            default: adv = 0;
        endcase
        if (adv && pos < 65535) pos++;
    endfunction

    // Works out the result a frame ends with and queues it.
    function automatic void close_frame();
        t_frame_result r;
        r.v = '0;
        r.count = '0;
        if (ph == PH_GTP || ph == PH_PLAIN) begin
            r.v.packet_class = ClassUdp;
        end else if (ph >= PH_OPT && ph <= PH_INNER) begin
            r.v.packet_class = ClassTunnel;
            r.v.parse_status = StatusTrunc;
        end else if (ph >= PH_DONE0) begin
            r.v.packet_class = ClassTunnel;
            case (ph)
                PH_DONE0: r.v.parse_status = StatusOk;
                PH_DONE2: r.v.parse_status = StatusBadExtLen;
                PH_DONE3: r.v.parse_status = StatusLongChain;
                default:  r.v.parse_status = StatusInnerBad;
            endcase
        end
        if (r.v.packet_class == ClassUdp) begin
            udp_cnt++;
            r.v.outer_addresses = fc[FcOuterAddr];
            r.v.outer_ports = fc[FcPorts][31:0];
            r.count = udp_cnt;
        end else if (r.v.packet_class == ClassTunnel) begin
            tunnel_cnt++;
            r.v.outer_addresses = fc[FcOuterAddr];
            r.v.outer_ports = fc[FcPorts][31:0];
            r.v.tunnel_id = fc[FcTeid][31:0];
            r.v.tunnel_header_info = fc[FcHdr][23:0];
            r.v.sequence_and_npdu = fc[FcSeq][25:0];
            r.v.extension_chain = fc[FcChain][34:0];
            r.v.session_info = fc[FcSession][10:0];
            if (ph == PH_DONE0) begin
                r.v.inner_addresses = fc[FcInnerAddr];
                r.v.inner_info = fc[FcInnerInfo][8:0];
            end
            r.count = tunnel_cnt;
        end
        expected_results.push_back(r);
        clear_frame_state();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_frame_result e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_if.packet_class), 64'd0);
            end else begin
                e = expected_results.pop_front();
                if (out_if.packet_class !== e.v.packet_class)
                    report_mismatch("packet_class", 64'(out_if.packet_class),
                                    64'(e.v.packet_class));
                if (out_if.outer_addresses !== e.v.outer_addresses)
                    report_mismatch("outer_addresses", out_if.outer_addresses,
                                    e.v.outer_addresses);
                if (out_if.outer_ports !== e.v.outer_ports)
                    report_mismatch("outer_ports", 64'(out_if.outer_ports),
                                    64'(e.v.outer_ports));
                if (out_if.tunnel_id !== e.v.tunnel_id)
                    report_mismatch("tunnel_id", 64'(out_if.tunnel_id), 64'(e.v.tunnel_id));
                if (out_if.tunnel_header_info !== e.v.tunnel_header_info)
                    report_mismatch("tunnel_header_info", 64'(out_if.tunnel_header_info),
                                    64'(e.v.tunnel_header_info));
                if (out_if.sequence_and_npdu !== e.v.sequence_and_npdu)
                    report_mismatch("sequence_and_npdu", 64'(out_if.sequence_and_npdu),
                                    64'(e.v.sequence_and_npdu));
                if (out_if.extension_chain !== e.v.extension_chain)
                    report_mismatch("extension_chain", 64'(out_if.extension_chain),
                                    64'(e.v.extension_chain));
                if (out_if.session_info !== e.v.session_info)
                    report_mismatch("session_info", 64'(out_if.session_info),
                                    64'(e.v.session_info));
                if (out_if.inner_addresses !== e.v.inner_addresses)
                    report_mismatch("inner_addresses", out_if.inner_addresses,
                                    e.v.inner_addresses);
                if (out_if.inner_info !== e.v.inner_info)
                    report_mismatch("inner_info", 64'(out_if.inner_info),
                                    64'(e.v.inner_info));
                if (out_if.parse_status !== e.v.parse_status)
                    report_mismatch("parse_status", 64'(out_if.parse_status),
                                    64'(e.v.parse_status));
                if (out_if.class_count !== e.count)
                    report_mismatch("class_count", 64'(out_if.class_count), 64'(e.count));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_if.ready <= 1'b0;
            hold_off--;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 15) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.frame_byte <= b;
        in_if.frame_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        parse_byte(b);
        if (last) close_frame();
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [AddrWidth-1:0] a, input logic [15:0] d);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= {16'($urandom_range(0, 65535)), d};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == RegTunnelPort) port_main = d;
        else port_alt = d;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_ports(input logic [15:0] p0, input logic [15:0] p1);
        wait_drained();
        apb_write(RegTunnelPort, p0);
        apb_write(RegTunnelPortAlt, p1);
    endtask

    function automatic void put16(input logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endfunction

    function automatic void put_rand(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    // Builds one frame. ext_n extensions are appended whether or not the E flag is set;
    // bad_at picks the extension with a broken length (-1 for none); cut > 0
    // keeps only the first cut bytes.
    function automatic void build_frame(input logic [15:0] eth_kind, input logic [7:0] ovih,
                                        input logic [7:0] proto, input logic [15:0] sport,
                                        input logic [15:0] dport, input logic [7:0] gflags,
                                        input logic [7:0] gmsg, input int ext_n,
                                        input logic [7:0] tail_next, input int bad_at,
                                        input int ext_words, input logic [7:0] ivih,
                                        input int cut);
        logic [7:0] kinds [8];
        logic [7:0] lb;
        int         words;
        frame_bytes.delete();
        put_rand(12);
        put16(eth_kind);
        frame_bytes.push_back(ovih);
        put_rand(8);
        frame_bytes.push_back(proto);
        put_rand(10);
        if (ovih[3:0] > 5) put_rand((ovih[3:0] - 5) * 4);
        put16(sport);
        put16(dport);
        put_rand(4);
        frame_bytes.push_back(gflags);
        frame_bytes.push_back(gmsg);
        put_rand(6);
        for (int k = 0; k < 8; k++)
            kinds[k] = ($urandom_range(0, 99) < 45) ? ContainerType : 8'($urandom_range(1, 255));
        if (gflags[2:0] != 0) begin
            put_rand(3);
            frame_bytes.push_back(ext_n > 0 ? kinds[0] : (gflags[2] ? 8'd0 : 8'($urandom)));
        end
        for (int k = 0; k < ext_n; k++) begin
            if (k == bad_at) lb = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(65, 255));
            else lb = 8'($urandom_range(1, ext_words));
            frame_bytes.push_back(lb);
            words = (lb == 0 || lb > 64) ? 1 : lb;
            put_rand(words * 4 - 2);
            frame_bytes.push_back(k < ext_n - 1 ? kinds[k + 1] : tail_next);
        end
        frame_bytes.push_back(ivih);
        put_rand(8);
        frame_bytes.push_back(8'($urandom));
        put_rand(10);
        if (ivih[3:0] > 5) put_rand((ivih[3:0] - 5) * 4);
        put_rand($urandom_range(0, 8));
        if (cut > 0 && cut < frame_bytes.size())
            frame_bytes = frame_bytes[0:cut-1];
    endfunction

    function automatic logic [15:0] any_port(input bit tunnel);
        if (!tunnel) return 16'($urandom);
        return $urandom_range(0, 1) ? port_main : port_alt;
    endfunction

    // A mostly well-formed frame with random content and occasional defects.
    function automatic void random_frame();
        int         r, n, cut;
        bit         tnl;
        logic [7:0] fl, ov, iv;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            frame_bytes.delete();
            put_rand($urandom_range(1, 70));
            return;
        end
        tnl = $urandom_range(0, 99) < 75;
        fl = ($urandom_range(0, 99) < 90) ? {3'd1, 1'b1, 1'b0, 3'($urandom)} : 8'($urandom);
        ov = ($urandom_range(0, 99) < 85) ? 8'h45 :
             {4'($urandom), ($urandom_range(0, 1) ? 4'($urandom_range(5, 15)) : 4'($urandom))};
        iv = ($urandom_range(0, 99) < 85) ? {4'd4, 4'($urandom_range(5, 7))} : 8'($urandom);
        n = $urandom_range(0, 5);
        cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 110) : 0;
        build_frame(($urandom_range(0, 99) < 93) ? 16'h0800 : 16'($urandom), ov,
                    ($urandom_range(0, 99) < 93) ? 8'd17 : 8'($urandom),
                    ($urandom_range(0, 1) && tnl) ? any_port(1) : 16'($urandom),
                    any_port(tnl), fl,
                    ($urandom_range(0, 99) < 93) ? 8'd255 : 8'($urandom), n,
                    ($urandom_range(0, 99) < 70) ? 8'd0 : 8'($urandom),
                    ($urandom_range(0, 99) < 8) ? $urandom_range(0, n) : -1,
                    ($urandom_range(0, 99) < 3) ? 64 : 3, iv, cut);
    endfunction

    task automatic test_directed();
        // Plain UDP ending with its header, then the shortest tunnel frame.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd53, 16'd53, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 42);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1000, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 0);
        send_frame();
        // All flags, a chain of two extensions, outer and inner options.
        build_frame(16'h0800, 8'h4f, 8'd17, port_alt, 16'hffff, 8'h37, 8'd255, 2, 0, -1, 2,
                    8'h4f, 0);
        send_frame();
        // Sequence only and N-PDU only.
        build_frame(16'h0800, 8'h45, 8'd17, 16'h0000, port_alt, 8'h32, 8'd255, 0, 0, -1, 1,
                    8'h45, 0);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'h0000, port_alt, 8'h31, 8'd255, 0, 0, -1, 1,
                    8'h45, 0);
        send_frame();
        // Not IPv4, not UDP, bad outer header length.
        build_frame(16'h86dd, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 20);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd6, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 34);
        send_frame();
        build_frame(16'h0800, 8'h44, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 34);
        send_frame();
        // Tunnel port but not a G-PDU; GTP header cut short.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h50, 8'd255, 0, 0, -1, 1,
                    8'h45, 50);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd1, 0, 0, -1, 1,
                    8'h45, 50);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 47);
        send_frame();
        // UDP header cut short, and a frame of a single byte.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h45, 38);
        send_frame();
        frame_bytes = {8'hff};
        send_frame();
        // Truncated inside the optional bytes, an extension and the inner header.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h36, 8'd255, 1, 0, -1, 1,
                    8'h45, 52);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h34, 8'd255, 1, 0, -1, 2,
                    8'h45, 56);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h46, 70);
        send_frame();
        // Bad extension length, two chains too long, an extension of up to 64 words.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h34, 8'd255, 2, 0, 1, 1,
                    8'h45, 0);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h34, 8'd255, 5, 0, -1, 1,
                    8'h45, 0);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h34, 8'd255, 4, 8'h85, -1, 1,
                    8'h45, 0);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h34, 8'd255, 1, 0, -1, 64,
                    8'h45, 0);
        send_frame();
        // Inner header not IPv4, and inner header length too small.
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h65, 0);
        send_frame();
        build_frame(16'h0800, 8'h45, 8'd17, 16'd1, port_main, 8'h30, 8'd255, 0, 0, -1, 1,
                    8'h43, 0);
        send_frame();
    endtask

    task automatic test_random(input int byte_goal, input int frame_goal);
        int nbytes, nframes;
        nbytes = 0;
        nframes = 0;
        while (nbytes < byte_goal || nframes < frame_goal) begin
            random_frame();
            calm = ($urandom_range(0, 99) < 10);
            send_frame();
            nbytes += frame_bytes.size();
            nframes++;
        end
        calm = 0;
    endtask

    // The receiver holds off while frames keep coming, so the input backs up.
    task automatic test_backpressure();
        hold_off = 400;
        repeat (4) begin
            random_frame();
            send_frame();
        end
    endtask

    initial begin
        port_main = TunnelPortReset;
        port_alt = TunnelPortAltReset;
        tunnel_cnt = '0;
        udp_cnt = '0;
        clear_frame_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(100, 2);
        test_backpressure();
        set_ports(16'h0000, 16'hffff);
        test_random(150, 2);
        set_ports(16'($urandom), 16'($urandom));
        test_random(60, 1);
        set_ports(TunnelPortAltReset, TunnelPortReset);
        test_random(60, 1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
